// ===== rtl/core/dtw_pkg.sv =====
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared types and constants of the depth to world projection core.
// ----------------------------------------------------------------------------
package dtw_pkg;

    localparam int PIX_W      = 10;
    localparam int RAW_W      = 11;
    localparam int OUT_W      = 32;
    // signed width of a*raw + b, positive range of the denominator
    localparam int DEN_SW     = 46;
    localparam int DEN_W      = 44;
    // quotient bits produced by the divider chain, one per cell
    localparam int QW         = 31;
    localparam int CTR_W      = 26;
    localparam int INVF_W     = 32;
    localparam int COEF_A_W   = 33;
    localparam int COEF_B_W   = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 96;

    localparam logic signed [COEF_A_W-1:0] COEF_A_RST = -33'sd13190279;
    localparam logic [COEF_B_W-1:0]        COEF_B_RST = 36'd14306319236;
    localparam logic [INVF_W-1:0]          INV_FX_RST = 32'd7227976;
    localparam logic [INVF_W-1:0]          INV_FY_RST = 32'd7266790;
    localparam logic [CTR_W-1:0]           CTR_X_RST  = 26'd22236876;
    localparam logic [CTR_W-1:0]           CTR_Y_RST  = 26'd15908150;

    localparam logic [QW-1:0] DEPTH_MAX = {QW{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_INV_FX = 3'd2,
        CFG_INV_FY = 3'd3,
        CFG_CTR_X  = 3'd4,
        CFG_CTR_Y  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             zero;
        logic             sat;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QW-1:0]    num;
        logic [QW-1:0]    q;
        t_side            side;
    } t_div;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] z;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] x;
    } t_point;

endpackage

// ===== rtl/core/dtw_div_cell.sv =====
// ----------------------------------------------------------------------------
// dtw_div_cell
// One restoring division step: shifts in one numerator bit, produces one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module dtw_div_cell
    import dtw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_div i_stage,
    output logic o_vld,
    output t_div o_stage
);

    logic         r_vld;
    t_div         r_stage;
    t_div         n_stage;
    logic [DEN_W:0] w_rem2;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_rem2 = {i_stage.rem, i_stage.num[QW-1]};
    assign w_diff = w_rem2 - {1'b0, i_stage.den};
    assign w_ge   = (w_rem2 >= {1'b0, i_stage.den});

    always_comb begin
        n_stage      = i_stage;
        n_stage.rem  = w_ge ? w_diff[DEN_W-1:0] : w_rem2[DEN_W-1:0];
        n_stage.num  = {i_stage.num[QW-2:0], 1'b0};
        n_stage.q    = {i_stage.q[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

    // remainder stays below the divisor for every live division
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_stage.side.zero && !r_stage.side.sat) |->
        (r_stage.rem < r_stage.den))
        else $error("division remainder not below divisor");

endmodule

// ===== rtl/core/dtw_proj_axis.sv =====
// ----------------------------------------------------------------------------
// dtw_proj_axis
// Projects one pixel offset through a reciprocal focal length and the depth
// word; two register stages, rounding and saturation at the output.
// ----------------------------------------------------------------------------
module dtw_proj_axis
    import dtw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PIX_W-1:0]  i_pix,
    input  logic [CTR_W-1:0]  i_center,
    input  logic [INVF_W-1:0] i_inv_f,
    input  logic [QW-1:0]     i_depth,
    output logic [OUT_W-1:0]  o_coord,
    output logic              o_sat
);

    localparam int D_W   = CTR_W + 1;
    localparam int A_W   = CTR_W + INVF_W;
    localparam int LO_W  = 32 + QW;
    localparam int HI_W  = (A_W - 32) + QW;
    localparam int MID_W = HI_W + 1;
    localparam int R_W   = MID_W - 16;

    logic [D_W-1:0]   w_d;
    logic [CTR_W-1:0] w_mag;
    logic [A_W-1:0]   w_a;

    logic [A_W-1:0]   r_a;
    logic             r_neg1;
    logic [QW-1:0]    r_dw;
    logic [LO_W-1:0]  r_lo;
    logic [HI_W-1:0]  r_hi;
    logic             r_neg2;

    logic [MID_W-1:0] w_mid;
    logic [R_W-1:0]   w_r;
    logic [OUT_W-1:0] w_neg_val;

    assign w_d   = {1'b0, i_pix, 16'b0} - {1'b0, i_center};
    assign w_mag = w_d[D_W-1] ? CTR_W'(-w_d) : w_d[CTR_W-1:0];
    assign w_a   = A_W'(w_mag) * A_W'(i_inv_f);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= w_a;
            r_neg1 <= w_d[D_W-1];
            r_dw   <= i_depth;
            r_lo   <= LO_W'(r_a[31:0]) * LO_W'(r_dw);
            r_hi   <= HI_W'(r_a[A_W-1:32]) * HI_W'(r_dw);
            r_neg2 <= r_neg1;
        end
    end

    // total product shifted right by 48, rounded half up
    assign w_mid     = MID_W'(r_lo[LO_W-1:32]) + MID_W'(r_hi) + MID_W'(17'h08000);
    assign w_r       = w_mid[MID_W-1:16];
    assign w_neg_val = OUT_W'(-w_r);

    always_comb begin
        if (!r_neg2) begin
            o_sat   = |w_r[R_W-1:31];
            o_coord = o_sat ? 32'h7FFF_FFFF : w_r[31:0];
        end else begin
            o_sat   = (|w_r[R_W-1:32]) || (w_r[31] && (|w_r[30:0]));
            o_coord = o_sat ? 32'h8000_0000 : w_neg_val;
        end
    end

endmodule

// ===== rtl/core/dtw_out_buf.sv =====
// ----------------------------------------------------------------------------
// dtw_out_buf
// Output register with a skid stage; the upstream ready is a register.
// ----------------------------------------------------------------------------
module dtw_out_buf
    import dtw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_point i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_point o_data
);

    logic   r_out_v;
    logic   r_skid_v;
    t_point r_out;
    t_point r_skid;
    logic   w_to_skid;
    logic   w_load_out;

    assign w_to_skid  = !r_skid_v && i_valid && r_out_v && !i_ready;
    assign w_load_out = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_to_skid) begin
                r_skid_v <= 1'b1;
            end else if (i_ready) begin
                r_skid_v <= 1'b0;
            end
            if (w_load_out) begin
                r_out_v <= r_skid_v || i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_to_skid) begin
            r_skid <= i_data;
        end
        if (w_load_out) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_ready) |=> (r_skid_v && $stable(r_skid)))
        else $error("stalled skid stage lost its request");

endmodule

// ===== rtl/core/depth_to_world_projection_core.sv =====
// ----------------------------------------------------------------------------
// depth_to_world_projection_core
// Turns depth pixels into world points through a pinhole camera model.
//
//   channel  | direction | fields (lowest bit up)
//   ---------+-----------+----------------------------------------------------
//   s_axis   | in        | tdata: pixel_col, pixel_row, raw_depth
//   m_axis   | out       | tdata: world_x, world_y, world_z; tuser: point_valid
//   cfg      | in        | i_cfg_index selects register, i_cfg_data its value
//
// One pixel per clock while the output is not stalled; stages: denominator,
// divider setup, 31 division cells (one quotient bit each), two projection
// stages, output reg. The 31-cell divider chain sets the latency.
// Reset is synchronous: it clears all valid flags and loads default intrinsics.
// Output stall: a skid stage takes one more request, then the pipeline holds.
// ----------------------------------------------------------------------------
module depth_to_world_projection_core
    import dtw_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16,
    parameter int RAW_INVALID   = 2047
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_col, pixel_row, raw_depth
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // world_x, world_y, world_z
    output logic [0:0]            m_axis_tuser,   // point_valid
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_TOP = 32 + OUT_FRAC_BITS;
    localparam int NUM_W   = ((NUM_TOP > (DEN_W - 1)) ? NUM_TOP : (DEN_W - 1)) + 1;
    localparam int NHI_W   = NUM_W - QW;
    localparam int RCMP_W  = 17;
    localparam int PROD_W  = COEF_A_W + RAW_W + 1;
    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << NUM_TOP;

    // configuration registers
    logic signed [COEF_A_W-1:0] r_coef_a;
    logic [COEF_B_W-1:0]        r_coef_b;
    logic [INVF_W-1:0]          r_inv_fx;
    logic [INVF_W-1:0]          r_inv_fy;
    logic [CTR_W-1:0]           r_ctr_x;
    logic [CTR_W-1:0]           r_ctr_y;

    logic                      w_en;
    logic [PIX_W-1:0]          w_col;
    logic [PIX_W-1:0]          w_row;
    logic [RAW_W-1:0]          w_raw;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DEN_SW-1:0]  w_den;
    logic                      w_raw_bad;

    logic                      r_a_vld;
    logic signed [DEN_SW-1:0]  r_a_den;
    logic                      r_a_bad;
    logic [PIX_W-1:0]          r_a_col;
    logic [PIX_W-1:0]          r_a_row;

    logic [DEN_W-1:0]          w_dn;
    logic                      w_den_pos;
    logic [NUM_W-1:0]          w_num;
    logic [NHI_W-1:0]          w_num_hi;
    t_div                      n_b;

    logic                      r_b_vld;
    t_div                      r_b;

    logic                      w_vld [0:QW];
    t_div                      w_stage [0:QW];

    t_side                     w_side;
    logic [QW-1:0]             w_depth;
    logic [OUT_W-1:0]          w_x;
    logic [OUT_W-1:0]          w_y;
    logic                      w_sat_x;
    logic                      w_sat_y;

    logic                      r_p1_vld;
    logic                      r_p1_zero;
    logic                      r_p1_sat;
    logic [QW-1:0]             r_p1_z;
    logic                      r_p2_vld;
    logic                      r_p2_zero;
    logic                      r_p2_sat;
    logic [QW-1:0]             r_p2_z;

    t_point                    w_point;
    t_point                    w_out;

    // configuration port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= COEF_A_RST;
            r_coef_b <= COEF_B_RST;
            r_inv_fx <= INV_FX_RST;
            r_inv_fy <= INV_FY_RST;
            r_ctr_x  <= CTR_X_RST;
            r_ctr_y  <= CTR_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_A: begin
                    r_coef_a <= $signed(i_cfg_data[COEF_A_W-1:0]);
                end
                CFG_COEF_B: begin
                    r_coef_b <= i_cfg_data[COEF_B_W-1:0];
                end
                CFG_INV_FX: begin
                    r_inv_fx <= i_cfg_data[INVF_W-1:0];
                end
                CFG_INV_FY: begin
                    r_inv_fy <= i_cfg_data[INVF_W-1:0];
                end
                CFG_CTR_X: begin
                    r_ctr_x <= i_cfg_data[CTR_W-1:0];
                end
                CFG_CTR_Y: begin
                    r_ctr_y <= i_cfg_data[CTR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage a: denominator a*raw + b
    assign w_col     = s_axis_tdata[PIX_W-1:0];
    assign w_row     = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign w_raw     = s_axis_tdata[2*PIX_W+RAW_W-1:2*PIX_W];
    assign w_prod    = r_coef_a * $signed({1'b0, w_raw});
    assign w_den     = DEN_SW'(w_prod)
                     + $signed({{(DEN_SW-COEF_B_W){1'b0}}, r_coef_b});
    assign w_raw_bad = (RCMP_W'(w_raw) >= RCMP_W'(RAW_INVALID));

    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_den <= w_den;
            r_a_bad <= w_raw_bad;
            r_a_col <= w_col;
            r_a_row <= w_row;
        end
    end

    // stage b: numerator 2^(32+f) + den/2, overflow check, first remainder
    assign w_den_pos = !r_a_den[DEN_SW-1] && (r_a_den != '0);
    assign w_dn      = r_a_den[DEN_W-1:0];
    assign w_num     = NUM_ONE + NUM_W'(w_dn >> 1);
    assign w_num_hi  = w_num[NUM_W-1:QW];

    always_comb begin
        n_b.den       = w_dn;
        n_b.rem       = DEN_W'(w_num_hi);
        n_b.num       = w_num[QW-1:0];
        n_b.q         = '0;
        n_b.side.col  = r_a_col;
        n_b.side.row  = r_a_row;
        n_b.side.zero = r_a_bad || !w_den_pos;
        // quotient would not fit in the depth word
        n_b.side.sat  = (DEN_W'(w_num_hi) >= w_dn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b <= n_b;
        end
    end

    // divider chain, one quotient bit per cell
    assign w_vld[0]   = r_b_vld;
    assign w_stage[0] = r_b;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        dtw_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_stage (w_stage[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_side  = w_stage[QW].side;
    assign w_depth = w_side.sat ? DEPTH_MAX : w_stage[QW].q;

    dtw_proj_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pix    (w_side.col),
        .i_center (r_ctr_x),
        .i_inv_f  (r_inv_fx),
        .i_depth  (w_depth),
        .o_coord  (w_x),
        .o_sat    (w_sat_x)
    );

    dtw_proj_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pix    (w_side.row),
        .i_center (r_ctr_y),
        .i_inv_f  (r_inv_fy),
        .i_depth  (w_depth),
        .o_coord  (w_y),
        .o_sat    (w_sat_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_vld[QW];
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_zero <= w_side.zero;
            r_p1_sat  <= w_side.sat;
            r_p1_z    <= w_depth;
            r_p2_zero <= r_p1_zero;
            r_p2_sat  <= r_p1_sat;
            r_p2_z    <= r_p1_z;
        end
    end

    always_comb begin
        if (r_p2_zero) begin
            w_point = '0;
        end else begin
            w_point.x     = w_x;
            w_point.y     = w_y;
            w_point.z     = {1'b0, r_p2_z};
            w_point.valid = !(r_p2_sat || w_sat_x || w_sat_y);
        end
    end

    dtw_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p2_vld),
        .o_ready (w_en),
        .i_data  (w_point),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.z, w_out.y, w_out.x};
    assign m_axis_tuser = w_out.valid;

    a_depth_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[OUT_DATA_W-1])
        else $error("depth word negative");

    a_zero_depth_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[95:64] == 32'd0)) |->
        (m_axis_tdata[63:0] == 64'd0))
        else $error("lateral coordinate nonzero at zero depth");

endmodule

// ===== dv/tb_depth_to_world_projection_core.sv =====
// ----------------------------------------------------------------------------
// tb_depth_to_world_projection_core
// Checks the depth pixel to world point projection against an in-bench
// predictor: directed corner pixels and register extremes, the no-reading,
// bad-denominator and saturation paths, then random pixel streams over several
// calibrations with random idling on both sides and output backpressure.
// ----------------------------------------------------------------------------
module tb_depth_to_world_projection_core
    import dtw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_FRAC       = 16;
    localparam int RAW_NO_READING = 2047;
    localparam int GAP_MAX        = 5;
    localparam int PIPE_LATENCY   = 36;
    localparam int IDLE_LIMIT     = 4000;
    localparam int PRINT_MAX      = 50;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_B = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // pixel_col, pixel_row, raw_depth
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // world_x, world_y, world_z
    logic [0:0]            m_axis_tuser;   // point_valid
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // calibration as the predictor sees it
    logic signed [COEF_A_W-1:0] cal_coef_a;
    logic [COEF_B_W-1:0]        cal_coef_b;
    logic [INVF_W-1:0]          cal_inv_fx;
    logic [INVF_W-1:0]          cal_inv_fy;
    logic [CTR_W-1:0]           cal_ctr_x;
    logic [CTR_W-1:0]           cal_ctr_y;

    t_point pending_points[$];
    int     mismatch_cnt;
    int     idle_cycles;
    int     rx_hold_cycles;
    int     rx_hold_reqs;
    bit     src_gaps;
    bit     sink_gaps;

    depth_to_world_projection_core #(
        .OUT_FRAC_BITS (OUT_FRAC),
        .RAW_INVALID   (RAW_NO_READING)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] scale_axis(input logic [PIX_W-1:0] pix,
                                                    input logic [CTR_W-1:0] ctr,
                                                    input logic [INVF_W-1:0] inv_f,
                                                    input logic [63:0] depth_w,
                                                    inout logic sat);
        logic signed [27:0] offs;
        logic [26:0]        mag;
        logic [127:0]       prod;
        logic [63:0]        mag_r;
        offs  = $signed({2'b00, pix, 16'd0}) - $signed({2'b00, ctr});
        mag   = (offs < 0) ? 27'(-offs) : 27'(offs);
        prod  = mag * inv_f * depth_w;
        // round half up on the magnitude, drop 48 fraction bits
        mag_r = 64'((prod + (128'd1 << 47)) >> 48);
        if (offs >= 0) begin
            if (mag_r > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag_r[31:0];
        end
        if (mag_r > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return 32'd0 - mag_r[31:0];
    endfunction

    function automatic t_point project_pixel(input logic [PIX_W-1:0] col,
                                             input logic [PIX_W-1:0] row,
                                             input logic [RAW_W-1:0] raw);
        t_point             pt;
        logic signed [63:0] den;
        logic [63:0]        den_u;
        logic [63:0]        depth_w;
        logic               sat;
        pt  = '0;
        sat = 1'b0;
        if (raw >= RAW_NO_READING)
            return pt;
        den = cal_coef_a * $signed({1'b0, raw}) + $signed({1'b0, cal_coef_b});
        if (den <= 0)
            return pt;
        den_u   = den;
        depth_w = ((64'd1 << (32 + OUT_FRAC)) + (den_u >> 1)) / den_u;
        if (depth_w > 64'h7FFF_FFFF) begin
            depth_w = 64'h7FFF_FFFF;
            sat     = 1'b1;
        end
        pt.x     = scale_axis(col, cal_ctr_x, cal_inv_fx, depth_w, sat);
        pt.y     = scale_axis(row, cal_ctr_y, cal_inv_fy, depth_w, sat);
        pt.z     = depth_w[31:0];
        pt.valid = ~sat;
        return pt;
    endfunction

    task automatic reset_calibration();
        cal_coef_a = COEF_A_RST;
        cal_coef_b = COEF_B_RST;
        cal_inv_fx = INV_FX_RST;
        cal_inv_fy = INV_FY_RST;
        cal_ctr_x  = CTR_X_RST;
        cal_ctr_y  = CTR_Y_RST;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COEF_A: cal_coef_a = value[COEF_A_W-1:0];
            CFG_COEF_B: cal_coef_b = value[COEF_B_W-1:0];
            CFG_INV_FX: cal_inv_fx = value[INVF_W-1:0];
            CFG_INV_FY: cal_inv_fy = value[INVF_W-1:0];
            CFG_CTR_X:  cal_ctr_x  = value[CTR_W-1:0];
            CFG_CTR_Y:  cal_ctr_y  = value[CTR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_calibration(input logic [CFG_DATA_W-1:0] coef_a,
                                    input logic [CFG_DATA_W-1:0] coef_b,
                                    input logic [CFG_DATA_W-1:0] inv_fx,
                                    input logic [CFG_DATA_W-1:0] inv_fy,
                                    input logic [CFG_DATA_W-1:0] ctr_x,
                                    input logic [CFG_DATA_W-1:0] ctr_y);
        write_reg(CFG_COEF_A, coef_a);
        write_reg(CFG_COEF_B, coef_b);
        write_reg(CFG_INV_FX, inv_fx);
        write_reg(CFG_INV_FY, inv_fy);
        write_reg(CFG_CTR_X, ctr_x);
        write_reg(CFG_CTR_Y, ctr_y);
    endtask

    task automatic load_default_calibration();
        load_calibration(CFG_DATA_W'(COEF_A_RST), CFG_DATA_W'(COEF_B_RST),
                         CFG_DATA_W'(INV_FX_RST), CFG_DATA_W'(INV_FY_RST),
                         CFG_DATA_W'(CTR_X_RST), CFG_DATA_W'(CTR_Y_RST));
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] col,
                              input logic [PIX_W-1:0] row,
                              input logic [RAW_W-1:0] raw);
        int gap;
        gap = src_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, raw, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_points.push_back(project_pixel(col, row, raw));
    endtask

    task automatic send_random_pixel();
        logic [RAW_W-1:0] raw;
        int               pick;
        pick = $urandom_range(0, 19);
        // lean toward disparities that still give a positive denominator
        if (pick == 0)
            raw = RAW_W'(RAW_NO_READING);
        else if (pick < 12)
            raw = RAW_W'($urandom_range(0, 1100));
        else
            raw = RAW_W'($urandom_range(0, 2047));
        send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)), raw);
    endtask

    task automatic wait_for_points();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int holds_done;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever begin
            if (rx_hold_reqs != holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                holds_done++;
            end
            stall = sink_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold_reqs == holds_done);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        if (mismatch_cnt < PRINT_MAX)
            $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got_v, exp_v);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : point_check
        t_point exp_pt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected point, world_x", m_axis_tdata[31:0], '0);
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_axis_tdata[31:0] !== exp_pt.x)
                    report_mismatch("world_x", m_axis_tdata[31:0], exp_pt.x);
                if (m_axis_tdata[63:32] !== exp_pt.y)
                    report_mismatch("world_y", m_axis_tdata[63:32], exp_pt.y);
                if (m_axis_tdata[95:64] !== exp_pt.z)
                    report_mismatch("world_z", m_axis_tdata[95:64], exp_pt.z);
                if (m_axis_tuser[0] !== exp_pt.valid)
                    report_mismatch("point_valid", 32'(m_axis_tuser[0]), 32'(exp_pt.valid));
            end
        end
    end

    // counts cycles without any request going through
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_depth_to_world_projection_core failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_corner_pixels();
        // default calibration goes non-positive just above raw 1084
        send_pixel(10'd0, 10'd0, 11'd0);
        send_pixel(10'd1023, 10'd1023, 11'd0);
        send_pixel(10'd1023, 10'd0, 11'd2046);
        send_pixel(10'd0, 10'd1023, 11'd1);
        send_pixel(10'd339, 10'd242, 11'd800);
        send_pixel(10'd512, 10'd384, 11'd600);
        send_pixel(10'd640, 10'd480, 11'd1083);
        send_pixel(10'd640, 10'd480, 11'd1084);
        send_pixel(10'd100, 10'd900, 11'd1085);
        send_pixel(10'd700, 10'd20, 11'(RAW_NO_READING));
        send_pixel(10'd1023, 10'd1023, 11'(RAW_NO_READING));
        wait_for_points();
    endtask

    task automatic test_register_writes();
        write_reg(CFG_IDX_UNUSED_A, 36'hF_FFFF_FFFF);
        write_reg(CFG_IDX_UNUSED_B, CFG_DATA_W'({$urandom, $urandom}));
        send_pixel(10'd0, 10'd1023, 11'd500);
        send_pixel(10'd1023, 10'd0, 11'd900);
        wait_for_points();

        // coef_a at its most negative, the unused top data bits set
        load_calibration(36'hF_0000_0000, 36'hF_FFFF_FFFF, 36'd0, 36'hF_FFFF_FFFF,
                         36'd0, 36'hF_FFFF_FFFF);
        send_pixel(10'd0, 10'd0, 11'd0);
        send_pixel(10'd1023, 10'd1023, 11'd15);
        send_pixel(10'd1023, 10'd0, 11'd16);
        wait_for_points();

        load_calibration(36'h0_FFFF_FFFF, 36'd0, 36'h0_FFFF_FFFF, 36'd0,
                         36'h0_03FF_FFFF, 36'd0);
        send_pixel(10'd0, 10'd1023, 11'd0);
        send_pixel(10'd0, 10'd1023, 11'd1);
        send_pixel(10'd1023, 10'd512, 11'd2046);
        wait_for_points();
    endtask

    task automatic test_saturation_paths();
        // denominator of one: depth far past full scale
        load_calibration(36'd0, 36'd1, CFG_DATA_W'(INV_FX_RST), CFG_DATA_W'(INV_FY_RST),
                         CFG_DATA_W'(CTR_X_RST), CFG_DATA_W'(CTR_Y_RST));
        send_pixel(10'd339, 10'd242, 11'd5);
        send_pixel(10'd1023, 10'd1023, 11'd2046);
        wait_for_points();

        // depth word lands exactly on 2^31, then just under it
        write_reg(CFG_COEF_B, 36'h2_0000);
        send_pixel(10'd339, 10'd242, 11'd77);
        wait_for_points();
        write_reg(CFG_COEF_B, 36'h2_0001);
        send_pixel(10'd339, 10'd242, 11'd77);
        send_pixel(10'd0, 10'd0, 11'd0);
        wait_for_points();

        // slope of -1: zero denominator at raw == b
        write_reg(CFG_COEF_A, 36'h1_FFFF_FFFF);
        write_reg(CFG_COEF_B, 36'd100);
        send_pixel(10'd400, 10'd300, 11'd99);
        send_pixel(10'd400, 10'd300, 11'd100);
        send_pixel(10'd400, 10'd300, 11'd101);
        wait_for_points();

        // lateral overflow of both signs with full-scale focal reciprocals
        load_calibration(36'd0, 36'h2_0001, 36'h0_FFFF_FFFF, 36'h0_FFFF_FFFF,
                         36'h0_03FF_FFFF, 36'd0);
        send_pixel(10'd0, 10'd1023, 11'd3);
        send_pixel(10'd1023, 10'd0, 11'd3);
        send_pixel(10'd1023, 10'd1, 11'd3);
        wait_for_points();
    endtask

    task automatic test_random_stream();
        longint coef_a_v;
        longint coef_b_v;
        longint inv_fx_v;
        longint inv_fy_v;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_default_calibration();
                5, 7: load_calibration(CFG_DATA_W'({$urandom, $urandom}),
                                       CFG_DATA_W'({$urandom, $urandom}),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                6: load_calibration(36'd0, CFG_DATA_W'($urandom_range(131072, 1048576)),
                                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom_range(0, 67108863)),
                                    CFG_DATA_W'($urandom_range(0, 67108863)));
                default: begin
                    // a slightly different camera around the default calibration
                    coef_a_v = longint'(COEF_A_RST) + longint'($urandom_range(0, 2097152))
                               - 1048576;
                    coef_b_v = longint'(COEF_B_RST) + longint'($urandom_range(0, 536870912))
                               - 268435456;
                    inv_fx_v = longint'(INV_FX_RST) + longint'($urandom_range(0, 8388608))
                               - 4194304;
                    inv_fy_v = longint'(INV_FY_RST) + longint'($urandom_range(0, 8388608))
                               - 4194304;
                    load_calibration(CFG_DATA_W'(coef_a_v), CFG_DATA_W'(coef_b_v),
                                     CFG_DATA_W'(inv_fx_v), CFG_DATA_W'(inv_fy_v),
                                     CFG_DATA_W'($urandom_range(0, 67108863)),
                                     CFG_DATA_W'($urandom_range(0, 67108863)));
                end
            endcase
            src_gaps  = (phase % 3) != 1;
            sink_gaps = (phase % 3) != 2;
            repeat (100) send_random_pixel();
            wait_for_points();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_output_backpressure();
        load_default_calibration();
        src_gaps       = 1'b0;
        // receiver closes long enough for the pipe and skid stage to fill up
        rx_hold_cycles = 300;
        rx_hold_reqs++;
        repeat (120) send_random_pixel();
        src_gaps = 1'b1;
        wait_for_points();
    endtask

    task automatic test_drain_pause();
        repeat (30) send_random_pixel();
        wait_for_points();
        repeat (30) send_random_pixel();
        wait_for_points();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        rx_hold_cycles = 0;
        rx_hold_reqs   = 0;
        src_gaps       = 1'b1;
        sink_gaps      = 1'b1;
        reset_calibration();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_pixels();
        test_register_writes();
        test_saturation_paths();
        test_random_stream();
        test_output_backpressure();
        test_drain_pause();

        wait_for_points();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_depth_to_world_projection_core passed");
        else
            $display("tb_depth_to_world_projection_core failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dtw_pkg.sv
rtl/core/dtw_div_cell.sv
rtl/core/dtw_proj_axis.sv
rtl/core/dtw_out_buf.sv
rtl/core/depth_to_world_projection_core.sv
dv/tb_depth_to_world_projection_core.sv
